// ===== src/cap_pkg.sv =====
// shared types and codes for the command apdu parser
package cap_pkg;

   // summary status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SHORT   = 3'd1;
   localparam logic [2:0] ST_TRUNC   = 3'd2;
   localparam logic [2:0] ST_OVERRUN = 3'd3;
   localparam logic [2:0] ST_TRAIL   = 3'd4;

   // iso command cases
   localparam logic [2:0] CASE_NONE     = 3'd0;
   localparam logic [2:0] CASE_HEADER   = 3'd1;
   localparam logic [2:0] CASE_LE       = 3'd2;
   localparam logic [2:0] CASE_DATA     = 3'd3;
   localparam logic [2:0] CASE_DATA_LE  = 3'd4;

   localparam logic [7:0] EXT_MARK   = 8'h00;
   localparam int         HDR_BYTES  = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic        data_valid;
      logic [7:0]  data_out;
      logic        done_res;
      logic [2:0]  status;
      logic [2:0]  apdu_case;
      logic [7:0]  class_byte;
      logic [7:0]  instruction_byte;
      logic [7:0]  param_one;
      logic [7:0]  param_two;
      logic [15:0] data_length;
      logic [15:0] expected_length;
   } res_type;

endpackage

// ===== src/cap_in_reg.sv =====
// input register holding one raw apdu word until the parser takes it
module cap_in_reg
   import cap_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   input  logic     take,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== src/cap_fsm.sv =====
// apdu phase tracker: header capture, length fields, data pass-through, summary
module cap_fsm
   import cap_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  item_type item,
   output logic     emit,
   output res_type  res
);

   typedef enum logic [3:0] {
      PH_HDR, PH_LEN1, PH_LEN1_HI, PH_LEN1_LO, PH_DATA,
      PH_LE, PH_LE_HI, PH_LE_LO, PH_SINK
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  hdr_ff [HDR_BYTES];
   logic [7:0]  hdr_cur [HDR_BYTES];
   logic        hdr_wr;
   logic        dv, fin;
   logic [2:0]  st, cs;
   logic [15:0] dlen, le, ext_val;
   logic [7:0]  b;

   assign b       = item.in_byte;
   assign ext_val = {high_ff, b};

   // header view with the byte being written bypassed in
   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         hdr_cur[i] = (hdr_wr && count_ff[1:0] == 2'(i)) ? b : hdr_ff[i];
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      high_in   = high_ff;
      hdr_wr    = 1'b0;
      dv        = 1'b0;
      fin       = 1'b0;
      st        = ST_OK;
      cs        = CASE_HEADER;
      dlen      = '0;
      le        = '0;
      unique case (phase_ff)
         PH_HDR: begin
            hdr_wr   = 1'b1;
            count_in = count_ff + 16'd1;
            if (count_ff[1:0] == 2'(HDR_BYTES - 1)) begin
               phase_in = PH_LEN1;
               fin      = item.last_byte;
            end else if (item.last_byte) begin
               fin = 1'b1;
               st  = ST_SHORT;
            end
         end
         PH_LEN1: begin
            if (item.last_byte) begin
               fin = 1'b1;
               cs  = CASE_LE;
               le  = {8'h00, b};
            end else if (b == EXT_MARK) begin
               phase_in = PH_LEN1_HI;
            end else begin
               length_in = {8'h00, b};
               count_in  = '0;
               phase_in  = PH_DATA;
            end
         end
         PH_LEN1_HI, PH_LE_HI: begin
            if (item.last_byte) begin
               fin = 1'b1;
               st  = ST_TRUNC;
            end else begin
               high_in  = b;
               phase_in = (phase_ff == PH_LEN1_HI) ? PH_LEN1_LO : PH_LE_LO;
            end
         end
         PH_LEN1_LO: begin
            if (item.last_byte) begin
               fin = 1'b1;
               cs  = CASE_LE;
               le  = ext_val;
            end else begin
               length_in = ext_val;
               count_in  = '0;
               // extended lc of zero goes straight to the le field
               phase_in  = (ext_val == '0) ? PH_LE : PH_DATA;
            end
         end
         PH_DATA: begin
            dv       = 1'b1;
            count_in = count_ff + 16'd1;
            if (count_in >= length_ff) begin
               if (item.last_byte) begin
                  fin  = 1'b1;
                  cs   = CASE_DATA;
                  dlen = length_ff;
               end else begin
                  phase_in = PH_LE;
               end
            end else if (item.last_byte) begin
               fin = 1'b1;
               st  = ST_OVERRUN;
            end
         end
         PH_LE: begin
            if (item.last_byte) begin
               fin  = 1'b1;
               cs   = CASE_DATA_LE;
               dlen = length_ff;
               le   = {8'h00, b};
            end else if (b == EXT_MARK) begin
               phase_in = PH_LE_HI;
            end else begin
               phase_in = PH_SINK;
            end
         end
         PH_LE_LO: begin
            if (item.last_byte) begin
               fin  = 1'b1;
               cs   = CASE_DATA_LE;
               dlen = length_ff;
               le   = ext_val;
            end else begin
               phase_in = PH_SINK;
            end
         end
         default: begin
            // trailing bytes are swallowed until the end of the apdu
            phase_in = PH_SINK;
            if (item.last_byte) begin
               fin = 1'b1;
               st  = ST_TRAIL;
            end
         end
      endcase
      if (fin) begin
         phase_in  = PH_HDR;
         count_in  = '0;
         length_in = '0;
         high_in   = '0;
      end
   end

   always_comb begin
      res            = '0;
      res.data_valid = dv;
      res.data_out   = dv ? b : 8'h00;
      res.done_res   = fin;
      if (fin) begin
         res.status    = st;
         res.apdu_case = (st == ST_OK) ? cs : CASE_HEADER;
         if (st == ST_OK) begin
            res.class_byte       = hdr_cur[0];
            res.instruction_byte = hdr_cur[1];
            res.param_one        = hdr_cur[2];
            res.param_two        = hdr_cur[3];
            res.data_length      = dlen;
            res.expected_length  = le;
         end
      end
   end

   assign emit = dv || fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         count_ff  <= '0;
         length_ff <= '0;
         high_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         high_ff   <= high_in;
      end
      if (step && hdr_wr) begin
         hdr_ff[count_ff[1:0]] <= b;
      end
   end

endmodule

// ===== src/cap_out_reg.sv =====
// result register in front of the rsp channel
module cap_out_reg
   import cap_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    emit,
   input  res_type res_in,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output res_type res_out
);

   logic    valid_ff, valid_in;
   res_type res_ff;

   assign rsp_valid = valid_ff;
   assign res_out   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (step && emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (step && emit) begin
         res_ff <= res_in;
      end
   end

endmodule

// ===== src/command_apdu_parser.sv =====
// Streaming command APDU parser.
// A command APDU enters on the req channel one word per cycle (req_in_byte)
// while req_ready is high, with req_last_byte set on its final word. Command
// data words leave on the rsp channel as they arrive (rsp_data_valid,
// rsp_data_out). The final word of an APDU also yields a summary
// (rsp_done_res) with status, ISO case, header bytes, Lc and Le; a nonzero
// status means the data words already delivered for this APDU should be
// dropped. Header and length words that end nothing give no rsp word at all.
// An accepted word waits in the input register and goes through the phase
// logic into the result register, which drives rsp_valid. Throughput is one
// word per cycle while rsp_ready is high.
// When rsp_ready is low the result register holds its word and the input
// register still takes one more word, after which req_ready drops until the
// receiver drains.
// Reset clears both registers and returns the parser to the start of an
// APDU; no clearing pass is needed.
module command_apdu_parser
   import cap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_apdu_case,
   output logic [7:0]  rsp_class_byte,
   output logic [7:0]  rsp_instruction_byte,
   output logic [7:0]  rsp_param_one,
   output logic [7:0]  rsp_param_two,
   output logic [15:0] rsp_data_length,
   output logic [15:0] rsp_expected_length
);

   item_type req_item, item;
   logic     item_valid, step, emit;
   res_type  res, res_out;

   assign req_item.in_byte   = req_in_byte;
   assign req_item.last_byte = req_last_byte;

   // parser advances whenever it holds a word and the result register can take one
   assign step = item_valid && (!rsp_valid || rsp_ready);

   cap_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   cap_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item),
      .emit  (emit),
      .res   (res)
   );

   cap_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .emit      (emit),
      .res_in    (res),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .res_out   (res_out)
   );

   assign rsp_data_valid       = res_out.data_valid;
   assign rsp_data_out         = res_out.data_out;
   assign rsp_done_res         = res_out.done_res;
   assign rsp_status           = res_out.status;
   assign rsp_apdu_case        = res_out.apdu_case;
   assign rsp_class_byte       = res_out.class_byte;
   assign rsp_instruction_byte = res_out.instruction_byte;
   assign rsp_param_one        = res_out.param_one;
   assign rsp_param_two        = res_out.param_two;
   assign rsp_data_length      = res_out.data_length;
   assign rsp_expected_length  = res_out.expected_length;

endmodule

// ===== src/cap_checker.sv =====
// port-level checks for the command apdu parser, bound to the top level
module cap_checker
   import cap_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_in_byte,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_data_valid,
   input logic [7:0]  rsp_data_out,
   input logic        rsp_done_res,
   input logic [2:0]  rsp_status,
   input logic [2:0]  rsp_apdu_case,
   input logic [7:0]  rsp_class_byte,
   input logic [7:0]  rsp_instruction_byte,
   input logic [7:0]  rsp_param_one,
   input logic [7:0]  rsp_param_two,
   input logic [15:0] rsp_data_length,
   input logic [15:0] rsp_expected_length
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_done_res) && $stable(rsp_status))
      else $error("rsp word changed while stalled");

   // every delivered word carries data or a summary
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data_valid || rsp_done_res)
      else $error("empty rsp word");

   // data-only words have status, case, lengths and class byte clear
   a_data_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == ST_OK
         && rsp_apdu_case == CASE_NONE && rsp_data_length == 16'h0000
         && rsp_expected_length == 16'h0000 && rsp_class_byte == 8'h00)
      else $error("summary fields set on data-only word");

   // error summaries report case one with class byte, p2 and lengths clear
   a_err_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_status != ST_OK |->
         rsp_apdu_case == CASE_HEADER && rsp_class_byte == 8'h00
         && rsp_param_two == 8'h00 && rsp_data_length == 16'h0000
         && rsp_expected_length == 16'h0000)
      else $error("malformed error summary");

   // ok summaries without lc report no data length
   a_ok_case: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_status == ST_OK
         && (rsp_apdu_case == CASE_HEADER || rsp_apdu_case == CASE_LE)
         |-> rsp_data_length == 16'h0000 && !rsp_data_valid)
      else $error("data length on case without lc");

endmodule

bind command_apdu_parser cap_checker u_cap_checker (.*);
